/* rtl/sfd_pkg.sv */
// Package for the status frame deframer: frame constants and the
// control/status structs shared by the controller and the datapath.
// No dependencies.
package sfd_pkg;

    // Header sequence that opens a frame
    localparam logic [7:0] HDR_FIRST  = 8'd205;
    localparam logic [7:0] HDR_SECOND = 8'd235;
    localparam logic [7:0] HDR_THIRD  = 8'd215;

    // Frame layout: five groups of five bytes
    localparam int STATUS_LEN  = 25;
    localparam int GROUPS      = 5;
    localparam int GROUP_BYTES = 5;

    localparam int ADDR_W  = $clog2(STATUS_LEN);
    localparam int INDEX_W = 3;
    localparam int POS_W   = 3;

    localparam logic [7:0]         STATUS_LEN_B  = 8'(STATUS_LEN);
    localparam logic [POS_W-1:0]   POS_LAST      = POS_W'(GROUP_BYTES - 1);
    localparam logic [INDEX_W-1:0] GROUP_LAST    = INDEX_W'(GROUPS - 1);

    // Commands from the controller to the datapath
    typedef struct packed {
        logic take;        // raise ready on the byte channel
        logic start;       // clear the group walk for a full frame
        logic rd;          // issue a payload read
        logic acc;         // fold the read byte into the word and sum
        logic load_out;    // load the result register when the check byte is read
        logic show;        // present the result item
        logic next_group;  // advance to the next group
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic in_valid;
        logic frame_done;  // the byte on the channel completes a 25-byte frame
        logic out_ready;
        logic pos_last;    // read byte is the check byte of its group
        logic group_last;  // current group is the fifth
    } status_t;

endpackage

/* rtl/sfd_in_if.sv */
// Byte channel interface: valid/ready handshake carrying one serial byte.
// No dependencies.
interface sfd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

/* rtl/sfd_out_if.sv */
// Status word channel interface: valid/ready handshake carrying one result item.
// Depends on sfd_pkg.
interface sfd_out_if;
    logic                           valid;
    logic                           ready;
    logic [sfd_pkg::INDEX_W-1:0]    word_index;
    logic [31:0]                    word_value;
    logic                           checksum_ok;
    logic                           last_word;

    modport source (output valid, output word_index, output word_value,
                    output checksum_ok, output last_word, input ready);
    modport sink (input valid, input word_index, input word_value,
                  input checksum_ok, input last_word, output ready);
endinterface

/* rtl/sfd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 25
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/sfd_ctrl.sv */
// Controller for the status frame deframer: receive, read, fold and present.
// Depends on sfd_pkg.
module sfd_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  sfd_pkg::status_t st,
    output sfd_pkg::cmd_t    cmd
);

    localparam logic [1:0] S_RX  = 2'd0;
    localparam logic [1:0] S_RD  = 2'd1;
    localparam logic [1:0] S_ACC = 2'd2;
    localparam logic [1:0] S_OUT = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_RX:
            begin
                cmd.take = 1'b1;
                if (st.in_valid && st.frame_done)
                begin
                    cmd.start  = 1'b1;
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                if (st.pos_last)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_OUT;
                end
                else
                begin
                    cmd.acc    = 1'b1;
                    state_next = S_RD;
                end
            end
            S_OUT:
            begin
                cmd.show = 1'b1;
                if (st.out_ready)
                begin
                    if (st.group_last)
                    begin
                        state_next = S_RX;
                    end
                    else
                    begin
                        cmd.next_group = 1'b1;
                        state_next     = S_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_RX;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_RX;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/sfd_datapath.sv */
// Datapath for the status frame deframer: header tracking, payload store,
// group word/checksum assembly and the result register.
// Depends on sfd_pkg, sfd_in_if, sfd_out_if and sfd_ram.
module sfd_datapath (
    input  logic             clk,
    input  logic             rst_n,
    sfd_in_if.sink           bytes,
    sfd_out_if.source        words,
    input  sfd_pkg::cmd_t    cmd,
    output sfd_pkg::status_t st
);

    logic [7:0] older_reg,  older_next;
    logic [7:0] newer_reg,  newer_next;
    logic       await_reg,  await_next;
    logic [7:0] target_reg, target_next;
    logic [7:0] count_reg,  count_next;

    logic [sfd_pkg::ADDR_W-1:0]  addr_reg,  addr_next;
    logic [sfd_pkg::POS_W-1:0]   pos_reg,   pos_next;
    logic [sfd_pkg::INDEX_W-1:0] group_reg, group_next;
    logic [31:0]                 word_reg,  word_next;
    logic [7:0]                  sum_reg,   sum_next;

    logic [sfd_pkg::INDEX_W-1:0] out_index_reg;
    logic [31:0]                 out_value_reg;
    logic                        out_ok_reg;
    logic                        out_last_reg;

    logic       in_fire;
    logic       header;
    logic       open_frame;
    logic [7:0] count_inc;
    logic       ram_we;
    logic [7:0] rd_byte;

    assign in_fire    = bytes.valid && cmd.take;
    assign header     = (older_reg == sfd_pkg::HDR_FIRST) &&
                        (newer_reg == sfd_pkg::HDR_SECOND) &&
                        (bytes.rx_byte == sfd_pkg::HDR_THIRD);
    assign open_frame = target_reg > count_reg;
    assign count_inc  = count_reg + 8'd1;
    assign ram_we     = in_fire && !header && !await_reg && open_frame &&
                        (count_reg < sfd_pkg::STATUS_LEN_B);

    // Frame tracking on each accepted byte
    always_comb
    begin
        older_next  = older_reg;
        newer_next  = newer_reg;
        await_next  = await_reg;
        target_next = target_reg;
        count_next  = count_reg;
        if (in_fire)
        begin
            older_next = newer_reg;
            newer_next = bytes.rx_byte;
            priority if (header)
            begin
                await_next  = 1'b1;
                target_next = 8'd0;
                count_next  = 8'd0;
            end
            else if (await_reg)
            begin
                target_next = bytes.rx_byte;
                await_next  = 1'b0;
            end
            else if (open_frame)
            begin
                if (count_inc == target_reg)
                begin
                    target_next = 8'd0;
                    count_next  = 8'd0;
                end
                else
                begin
                    count_next = count_inc;
                end
            end
        end
    end

    sfd_ram #(
        .WIDTH (8),
        .DEPTH (sfd_pkg::STATUS_LEN)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[sfd_pkg::ADDR_W-1:0]),
        .wdata (bytes.rx_byte),
        .re    (cmd.rd),
        .raddr (addr_reg),
        .rdata (rd_byte)
    );

    // Group walk: fold four bytes, compare the fifth
    always_comb
    begin
        addr_next  = addr_reg;
        pos_next   = pos_reg;
        group_next = group_reg;
        word_next  = word_reg;
        sum_next   = sum_reg;
        priority if (cmd.start)
        begin
            addr_next  = '0;
            pos_next   = '0;
            group_next = '0;
            word_next  = '0;
            sum_next   = '0;
        end
        else if (cmd.acc)
        begin
            word_next = {rd_byte, word_reg[31:8]};
            sum_next  = sum_reg + rd_byte;
            pos_next  = pos_reg + sfd_pkg::POS_W'(1);
            addr_next = addr_reg + sfd_pkg::ADDR_W'(1);
        end
        else if (cmd.next_group)
        begin
            word_next  = '0;
            sum_next   = '0;
            pos_next   = '0;
            group_next = group_reg + sfd_pkg::INDEX_W'(1);
            addr_next  = addr_reg + sfd_pkg::ADDR_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            older_reg  <= '0;
            newer_reg  <= '0;
            await_reg  <= 1'b0;
            target_reg <= '0;
            count_reg  <= '0;
            addr_reg   <= '0;
            pos_reg    <= '0;
            group_reg  <= '0;
        end
        else
        begin
            older_reg  <= older_next;
            newer_reg  <= newer_next;
            await_reg  <= await_next;
            target_reg <= target_next;
            count_reg  <= count_next;
            addr_reg   <= addr_next;
            pos_reg    <= pos_next;
            group_reg  <= group_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        sum_reg  <= sum_next;
        if (cmd.load_out)
        begin
            out_index_reg <= group_reg;
            out_value_reg <= word_reg;
            out_ok_reg    <= (sum_reg == rd_byte);
            out_last_reg  <= (group_reg == sfd_pkg::GROUP_LAST);
        end
    end

    assign bytes.ready       = cmd.take;
    assign words.valid       = cmd.show;
    assign words.word_index  = out_index_reg;
    assign words.word_value  = out_value_reg;
    assign words.checksum_ok = out_ok_reg;
    assign words.last_word   = out_last_reg;

    assign st.in_valid   = bytes.valid;
    assign st.frame_done = !header && !await_reg &&
                           (target_reg == sfd_pkg::STATUS_LEN_B) &&
                           (count_inc == sfd_pkg::STATUS_LEN_B);
    assign st.out_ready  = words.ready;
    assign st.pos_last   = (pos_reg == sfd_pkg::POS_LAST);
    assign st.group_last = (group_reg == sfd_pkg::GROUP_LAST);

endmodule

/* rtl/status_frame_deframer_top.sv */
// Status frame deframer top level. The byte that completes a 25-byte frame
// starts a walk of the payload store, byte by byte (registered RAM read, then
// fold); a word item is presented once its group's check byte has been read,
// and the next group's walk begins when that item is taken. Throughput: one
// byte per cycle outside of that walk; bytes are held off while a frame's five
// items go out. Reset clears framing state.
module status_frame_deframer_top (
    input  logic      clk,
    input  logic      rst_n,
    sfd_in_if.sink    bytes,
    sfd_out_if.source words
);

    // Commands and status between the controller and the datapath
    sfd_pkg::cmd_t    cmd;
    sfd_pkg::status_t st;

    // Controller: sequences receive, payload read, fold and item hand-off
    sfd_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .st    (st),
        .cmd   (cmd)
    );

    // Datapath: header detection, length/count tracking, payload store,
    // word and checksum assembly, and the result register
    sfd_datapath u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .bytes (bytes),
        .words (words),
        .cmd   (cmd),
        .st    (st)
    );

endmodule

/* bench/status_frame_deframer_top_tb.sv */
// Testbench for status_frame_deframer_top: drives serial bytes and checks the status
// word items against a cycle-free predictor of the deframing rules.
// Depends on sfd_pkg, sfd_in_if, sfd_out_if and the top level.
`timescale 1ns / 1ps

module status_frame_deframer_top_tb;

    // Generous bound for the whole run, long stalls on both sides included.
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_BYTES = 250;
    // Cycles to let pass after the last word item.
    localparam int DRAIN_CYCLES = 80;

    typedef struct packed {
        logic [sfd_pkg::INDEX_W-1:0] index;
        logic [31:0]                 value;
        logic                        ok;
        logic                        last;
    } status_word_t;

    logic clk;
    logic rst_n;

    sfd_in_if  bytes_ch ();
    sfd_out_if words_ch ();

    status_frame_deframer_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .bytes (bytes_ch),
        .words (words_ch)
    );

    // Predictor state: byte history, framing and the payload copy.
    logic [7:0] hist_older;
    logic [7:0] hist_newer;
    logic       want_length;
    logic [7:0] frame_length;
    logic [7:0] taken;
    logic [7:0] payload [sfd_pkg::STATUS_LEN];

    status_word_t pending_words [$];

    int  mismatch_count;
    int  bytes_sent;
    int  cycle_count;
    int  rx_hold_left;
    bit  rx_held;
    bit  tx_steady;
    bit  rx_steady;

    always #5 clk = ~clk;

    // Report one mismatch on a line of its own and count it.
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        $display("mismatch: %s got %0h want %0h (cycle %0d)", what, got, want, cycle_count);
    endtask

    // Gap length: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Advance the predictor by one accepted byte and queue any word items it completes.
    function automatic void deframe_byte(input logic [7:0] b);
        logic         is_header;
        logic [7:0]   sum;
        status_word_t w;
        is_header = (hist_older == sfd_pkg::HDR_FIRST) &&
                    (hist_newer == sfd_pkg::HDR_SECOND) &&
                    (b == sfd_pkg::HDR_THIRD);
        hist_older = hist_newer;
        hist_newer = b;
        // A header restarts framing from any state.
        if (is_header)
        begin
            want_length  = 1'b1;
            frame_length = '0;
            taken        = '0;
            return;
        end
        if (want_length)
        begin
            frame_length = b;
            want_length  = 1'b0;
            return;
        end
        // No open frame: zero length, or the frame already complete.
        if (frame_length <= taken)
            return;
        // Bytes past the 25th are counted but not kept.
        if (taken < sfd_pkg::STATUS_LEN)
            payload[taken] = b;
        taken = 8'(taken + 1);
        if (taken == frame_length)
        begin
            if (frame_length == sfd_pkg::STATUS_LEN_B)
            begin
                for (int g = 0; g < sfd_pkg::GROUPS; g++)
                begin
                    sum = 8'(payload[5*g] + payload[5*g+1] + payload[5*g+2] + payload[5*g+3]);
                    w.index = sfd_pkg::INDEX_W'(g);
                    w.value = {payload[5*g+3], payload[5*g+2], payload[5*g+1], payload[5*g]};
                    w.ok    = (sum == payload[5*g+4]);
                    w.last  = (g == sfd_pkg::GROUPS - 1);
                    pending_words.push_back(w);
                end
            end
            frame_length = '0;
            taken        = '0;
        end
    endfunction

    // Offer one byte after a random gap, hold it until taken, then return at the
    // next falling edge so the caller can keep valid high for a following byte.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = tx_steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            bytes_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        bytes_ch.valid   = 1'b1;
        bytes_ch.rx_byte = b;
        do
            @(posedge clk);
        while (!bytes_ch.ready);
        deframe_byte(b);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_header();
        send_byte(sfd_pkg::HDR_FIRST);
        send_byte(sfd_pkg::HDR_SECOND);
        send_byte(sfd_pkg::HDR_THIRD);
    endtask

    // Bytes leaning toward the header values, to hit partial and overlapping headers.
    function automatic logic [7:0] noise_byte();
        case ($urandom_range(0, 5))
            0:       return sfd_pkg::HDR_FIRST;
            1:       return sfd_pkg::HDR_SECOND;
            2:       return sfd_pkg::HDR_THIRD;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Send a complete 25-byte frame with random words; ok_pct sets how many check
    // bytes match their group.
    task automatic send_status_frame(input int ok_pct);
        logic [7:0] g_bytes [4];
        logic [7:0] sum;
        send_header();
        send_byte(sfd_pkg::STATUS_LEN_B);
        for (int g = 0; g < sfd_pkg::GROUPS; g++)
        begin
            for (int i = 0; i < 4; i++)
                g_bytes[i] = 8'($urandom_range(0, 255));
            sum = 8'(g_bytes[0] + g_bytes[1] + g_bytes[2] + g_bytes[3]);
            for (int i = 0; i < 4; i++)
                send_byte(g_bytes[i]);
            if ($urandom_range(0, 99) < ok_pct)
                send_byte(sum);
            else
                send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    // Bytes with no open frame right after reset; none of these may produce an item.
    task automatic test_idle_bytes();
        send_byte(8'd235);
        send_byte(8'd215);
        send_byte(8'd0);
    endtask

    // Abort a frame of the largest length with a new header, then send a full frame
    // whose groups carry all-zero, all-one, a bad check and mixed header bytes.
    task automatic test_status_frame();
        logic [7:0] frame [sfd_pkg::STATUS_LEN];
        frame = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                  8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFC,
                  8'h01, 8'h02, 8'h03, 8'h04, 8'h0B,
                  8'h80, 8'h7F, 8'h80, 8'h7F, 8'hFE,
                  8'hD7, 8'hEB, 8'hCD, 8'h12, 8'hA1};
        send_header();
        send_byte(8'd255);
        for (int i = 0; i < 4; i++)
            send_byte(8'($urandom_range(0, 255)));
        send_header();
        send_byte(sfd_pkg::STATUS_LEN_B);
        foreach (frame[i])
            send_byte(frame[i]);
    endtask

    // A length byte equal to the first header byte, a header formed across the
    // length and payload, then a zero-length frame followed by ignored bytes.
    task automatic test_restart_and_zero_length();
        send_header();
        send_byte(sfd_pkg::HDR_FIRST);
        send_byte(sfd_pkg::HDR_SECOND);
        send_byte(sfd_pkg::HDR_THIRD);
        send_byte(8'd0);
        send_byte(8'd1);
        send_byte(8'd25);
        send_byte(8'd255);
    endtask

    // Hold the word channel off for a long stretch while frames keep coming, so the
    // block fills up and stalls its byte input.
    task automatic test_output_backpressure();
        tx_steady    = 1'b1;
        rx_hold_left = 400;
        repeat (3)
            send_status_frame(100);
        tx_steady = 1'b0;
    endtask

    // Mostly well-formed frames with random content; the rest are other lengths,
    // truncated frames, frames cut by a new header, and noise.
    task automatic test_random_traffic();
        int start;
        int r;
        int len;
        start = bytes_sent;
        while (bytes_sent - start < RANDOM_BYTES)
        begin
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < 55)
                send_status_frame(70);
            else if (r < 65)
            begin
                case ($urandom_range(0, 3))
                    0:       len = 0;
                    1:       len = $urandom_range(26, 40);
                    default: len = $urandom_range(1, 24);
                endcase
                send_header();
                send_byte(8'(len));
                repeat (len)
                    send_byte(8'($urandom_range(0, 255)));
            end
            else if (r < 75)
            begin
                // Truncated: whatever follows may complete it.
                send_header();
                send_byte(sfd_pkg::STATUS_LEN_B);
                repeat ($urandom_range(0, 24))
                    send_byte(8'($urandom_range(0, 255)));
            end
            else if (r < 85)
            begin
                send_header();
                send_byte(sfd_pkg::STATUS_LEN_B);
                repeat ($urandom_range(0, 24))
                    send_byte(noise_byte());
                send_status_frame(70);
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                    send_byte(noise_byte());
            end
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    // Count the long hold-off in cycles; the receiver reads the flag at the falling edge.
    initial
    begin
        rx_held = 1'b0;
        forever
        begin
            @(posedge clk);
            rx_held = (rx_hold_left > 0);
            if (rx_hold_left > 0)
                rx_hold_left--;
        end
    end

    // Drive ready at the falling edge: random stalls, held low during a hold-off.
    initial
    begin
        int stall_left;
        stall_left     = 0;
        words_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_held)
                words_ch.ready = 1'b0;
            else if (stall_left > 0)
            begin
                words_ch.ready = 1'b0;
                stall_left--;
            end
            else
            begin
                words_ch.ready = 1'b1;
                if (!rx_steady && $urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    // Check each accepted word item against the oldest expectation.
    always @(posedge clk)
    begin
        status_word_t want;
        if (rst_n && words_ch.valid && words_ch.ready)
        begin
            if (pending_words.size() == 0)
                report_mismatch("unexpected item, word_value", words_ch.word_value, 32'h0);
            else
            begin
                want = pending_words.pop_front();
                if (words_ch.word_index !== want.index)
                    report_mismatch("word_index", 32'(words_ch.word_index), 32'(want.index));
                if (words_ch.word_value !== want.value)
                    report_mismatch("word_value", words_ch.word_value, want.value);
                if (words_ch.checksum_ok !== want.ok)
                    report_mismatch("checksum_ok", 32'(words_ch.checksum_ok), 32'(want.ok));
                if (words_ch.last_word !== want.last)
                    report_mismatch("last_word", 32'(words_ch.last_word), 32'(want.last));
            end
        end
    end

    // Stop a hung run.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        clk              = 1'b0;
        rst_n            = 1'b0;
        bytes_ch.valid   = 1'b0;
        bytes_ch.rx_byte = '0;
        hist_older       = '0;
        hist_newer       = '0;
        want_length      = 1'b0;
        frame_length     = '0;
        taken            = '0;
        mismatch_count   = 0;
        bytes_sent       = 0;
        rx_hold_left     = 0;
        tx_steady        = 1'b0;
        rx_steady        = 1'b0;

        // Hold reset, then release it away from the sampling edge.
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_idle_bytes();
        test_status_frame();
        test_restart_and_zero_length();
        test_output_backpressure();
        test_random_traffic();
        bytes_ch.valid = 1'b0;

        // Drain: wait for every expected item, then let the walk settle.
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
